// ===== src/grs_pkg.sv =====
// Shared types and constants for the group reverse stream block.
package grs_pkg;

    localparam int GRP_MAX_GROUP = 16;
    localparam int DATA_W        = 32;
    localparam int GSIZE_W       = 5;
    localparam int CNT_W         = 7;

    localparam logic [GSIZE_W-1:0] GSIZE_RESET = 5'd2;

    typedef struct packed {
        logic             half;
        logic [CNT_W-1:0] count;
        logic             rev;
        logic             last;
    } desc_t;

    typedef struct packed {
        logic valid;
        logic half;
    } rel_t;

endpackage

// ===== src/group_reverse_stream_top.sv =====
// Top level of the group reverse stream block.
// Output path: a closed group's descriptor passes the descriptor queue and the back-end descriptor
// register, each value the RAM read register and output register; the rest of the group follows at
// one value per cycle while m_axis_tready is high. Throughput: at most one transaction per cycle
// while s_axis_tready is high; a buffer half is freed only after its last value is read.
// Reset: rst_n clears all control state at once and sets group_size to 2; the group buffer
// holds no reset value and needs no clearing pass.
module group_reverse_stream_top import grs_pkg::*; #(
    parameter int MAX_GROUP = GRP_MAX_GROUP,
    localparam int IW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1,
    localparam int AW = IW + 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [GSIZE_W-1:0] cfg_wdata,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [DATA_W-1:0]  s_axis_tdata,   // [31:0] value
    input  logic               s_axis_tlast,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [DATA_W-1:0]  m_axis_tdata,   // [31:0] out_value
    output logic               m_axis_tlast
);

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    logic              q_push;
    desc_t             push_desc;
    logic              q_pop;
    logic              q_valid;
    logic              q_full;
    desc_t             q_head;
    rel_t              rel;

    grs_front #(
        .MAX_GROUP(MAX_GROUP)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_value  (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .push      (q_push),
        .push_desc (push_desc),
        .rel       (rel)
    );

    grs_desc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (push_desc),
        .pop       (q_pop),
        .valid     (q_valid),
        .full      (q_full),
        .head      (q_head)
    );

    grs_ram #(
        .WIDTH(DATA_W),
        .DEPTH(2 * (2 ** IW))
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    grs_back #(
        .MAX_GROUP(MAX_GROUP)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_desc    (q_head),
        .q_pop     (q_pop),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .rel       (rel),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_value (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

    a_no_queue_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("Descriptor pushed into a full queue.");

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("Descriptor popped from an empty queue.");

    a_release_other_half: assert property (@(posedge clk) disable iff (!rst_n)
        (rel.valid && q_push) |-> (rel.half != push_desc.half))
        else $error("A buffer half was closed and released in the same cycle.");

    a_read_not_written: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_re && ram_we) |-> (ram_raddr[AW-1] != ram_waddr[AW-1]))
        else $error("Buffer half read while it is being filled.");

endmodule

// ===== src/grs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module grs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/grs_front.sv =====
// Front end: accepts input transactions, fills the group halves and closes groups.
module grs_front import grs_pkg::*; #(
    parameter int MAX_GROUP = GRP_MAX_GROUP,
    localparam int IW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1,
    localparam int AW = IW + 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [GSIZE_W-1:0] cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [DATA_W-1:0]  in_value,
    input  logic               in_last,
    output logic               ram_we,
    output logic [AW-1:0]      ram_waddr,
    output logic [DATA_W-1:0]  ram_wdata,
    output logic               push,
    output desc_t              push_desc,
    input  rel_t               rel
);

    logic [GSIZE_W-1:0] gsize_reg, gsize_next;
    logic [IW-1:0]      fill_reg, fill_next;
    logic               half_reg, half_next;
    logic [1:0]         busy_reg, busy_next;

    logic [7:0] k;
    logic [7:0] n;
    logic       accept;
    logic       full_group;
    logic       close;

    always_comb
    begin
        if (gsize_reg == '0)
        begin
            k = 8'd1;
        end
        else if ({3'b000, gsize_reg} > 8'(MAX_GROUP))
        begin
            k = 8'(MAX_GROUP);
        end
        else
        begin
            k = {3'b000, gsize_reg};
        end
    end

    assign n          = 8'(fill_reg) + 8'd1;
    assign in_ready   = !busy_reg[half_reg];
    assign accept     = in_valid && in_ready;
    assign full_group = (n >= k);
    assign close      = accept && (full_group || in_last);

    assign ram_we    = accept;
    assign ram_waddr = {half_reg, fill_reg};
    assign ram_wdata = in_value;

    assign push            = close;
    assign push_desc.half  = half_reg;
    assign push_desc.count = CNT_W'(n);
    assign push_desc.rev   = full_group;
    assign push_desc.last  = in_last;

    always_comb
    begin
        gsize_next = cfg_we ? cfg_wdata : gsize_reg;
        fill_next  = fill_reg;
        half_next  = half_reg;
        busy_next  = busy_reg;
        if (rel.valid)
        begin
            busy_next[rel.half] = 1'b0;
        end
        priority if (close)
        begin
            fill_next           = '0;
            half_next           = !half_reg;
            busy_next[half_reg] = 1'b1;
        end
        else if (accept)
        begin
            fill_next = IW'(n);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gsize_reg <= GSIZE_RESET;
            fill_reg  <= '0;
            half_reg  <= 1'b0;
            busy_reg  <= '0;
        end
        else
        begin
            gsize_reg <= gsize_next;
            fill_reg  <= fill_next;
            half_reg  <= half_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

// ===== src/grs_desc_queue.sv =====
// Two-entry queue of group descriptors between the front and back ends.
module grs_desc_queue import grs_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_desc,
    input  logic  pop,
    output logic  valid,
    output logic  full,
    output desc_t head
);

    desc_t      mem_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign valid = (cnt_reg != 2'd0);
    assign full  = (cnt_reg == 2'd2);
    assign head  = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = push ? !wptr_reg : wptr_reg;
        rptr_next = pop ? !rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ===== src/grs_back.sv =====
// Back end: drains closed groups from the buffer in order and feeds the output queue.
module grs_back import grs_pkg::*; #(
    parameter int MAX_GROUP = GRP_MAX_GROUP,
    localparam int IW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1,
    localparam int AW = IW + 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  desc_t             q_desc,
    output logic              q_pop,
    output logic              ram_re,
    output logic [AW-1:0]     ram_raddr,
    input  logic [DATA_W-1:0] ram_rdata,
    output rel_t              rel,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_value,
    output logic              out_last
);

    logic              active_reg, active_next;
    desc_t             cur_reg, cur_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic              pend_reg;
    logic              pend_last_reg;
    logic [DATA_W-1:0] val_reg [2];
    logic              lst_reg [2];
    logic              wptr_reg;
    logic              rptr_reg;
    logic [1:0]        cnt_reg, cnt_next;

    logic             pop_out;
    logic [2:0]       occ;
    logic             space;
    logic             issue;
    logic             final_el;
    logic [CNT_W-1:0] idx_w;
    logic [CNT_W-1:0] ridx_w;

    assign out_valid = (cnt_reg != 2'd0);
    assign pop_out   = out_valid && out_ready;
    assign out_value = val_reg[rptr_reg];
    assign out_last  = lst_reg[rptr_reg];

    assign occ      = {1'b0, cnt_reg} + {2'b00, pend_reg};
    assign space    = (occ < 3'd2) || ((occ == 3'd2) && pop_out);
    assign issue    = active_reg && space;
    assign idx_w    = CNT_W'(idx_reg);
    assign final_el = ((idx_w + 1'b1) == cur_reg.count);
    assign ridx_w   = cur_reg.rev ? (cur_reg.count - 1'b1 - idx_w) : idx_w;

    assign ram_re    = issue;
    assign ram_raddr = {cur_reg.half, IW'(ridx_w)};
    assign rel.valid = issue && final_el;
    assign rel.half  = cur_reg.half;
    assign q_pop     = q_valid && (!active_reg || (issue && final_el));

    always_comb
    begin
        active_next = active_reg;
        cur_next    = cur_reg;
        idx_next    = idx_reg;
        priority if (q_pop)
        begin
            active_next = 1'b1;
            cur_next    = q_desc;
            idx_next    = '0;
        end
        else if (issue && final_el)
        begin
            active_next = 1'b0;
        end
        else if (issue)
        begin
            idx_next = idx_reg + 1'b1;
        end
        cnt_next = cnt_reg + {1'b0, pend_reg} - {1'b0, pop_out};
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            val_reg[wptr_reg] <= ram_rdata;
            lst_reg[wptr_reg] <= pend_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            cur_reg       <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            wptr_reg      <= 1'b0;
            rptr_reg      <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            active_reg    <= active_next;
            cur_reg       <= cur_next;
            idx_reg       <= idx_next;
            pend_reg      <= issue;
            pend_last_reg <= cur_reg.last && final_el;
            wptr_reg      <= pend_reg ? !wptr_reg : wptr_reg;
            rptr_reg      <= pop_out ? !rptr_reg : rptr_reg;
            cnt_reg       <= cnt_next;
        end
    end

endmodule

// ===== tb/sv/tb_group_reverse_stream_top.sv =====
// Self-checking testbench for the group reverse stream block.

class reorder_scoreboard;
    typedef struct packed {
        logic signed [grs_pkg::DATA_W-1:0] value;
        logic                              last;
    } result_t;

    logic [grs_pkg::GSIZE_W-1:0]       group_size;
    logic signed [grs_pkg::DATA_W-1:0] held [grs_pkg::GRP_MAX_GROUP];
    int unsigned                       held_count;
    result_t                           expected_q[$];
    int                                mismatches;

    function new();
        group_size = grs_pkg::GSIZE_RESET;
        held_count = 0;
        mismatches = 0;
    endfunction

    function void write_group_size(logic [grs_pkg::GSIZE_W-1:0] size_code);
        group_size = size_code;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void note_input(logic signed [grs_pkg::DATA_W-1:0] value, logic last);
        int unsigned span;
        int unsigned n;
        result_t     r;
        span = group_size;
        if (span == 0)
        begin
            span = 1;
        end
        if (span > grs_pkg::GRP_MAX_GROUP)
        begin
            span = grs_pkg::GRP_MAX_GROUP;
        end
        held[held_count] = value;
        n = held_count + 1;
        if (n >= span)
        begin
            for (int i = 0; i < n; i++)
            begin
                r.value = held[n - 1 - i];
                r.last  = last && (i == n - 1);
                expected_q.push_back(r);
            end
            held_count = 0;
        end
        else if (last)
        begin
            for (int i = 0; i < n; i++)
            begin
                r.value = held[i];
                r.last  = (i == n - 1);
                expected_q.push_back(r);
            end
            held_count = 0;
        end
        else
        begin
            held_count = n;
        end
    endfunction

    function void report_mismatch(string field, logic [63:0] exp_val, logic [63:0] act_val);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("mismatch %0d: %s expected %h got %h", mismatches, field, exp_val, act_val);
        end
    endfunction

    function void check_result(logic signed [grs_pkg::DATA_W-1:0] value, logic last);
        result_t r;
        if (expected_q.size() == 0)
        begin
            report_mismatch("unexpected transaction, out_value", 64'd0, 64'(value));
            return;
        end
        r = expected_q.pop_front();
        if (r.value !== value)
        begin
            report_mismatch("out_value", 64'(r.value), 64'(value));
        end
        if (r.last !== last)
        begin
            report_mismatch("out_last", 64'(r.last), 64'(last));
        end
    endfunction
endclass

module tb_group_reverse_stream_top;
    import grs_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RX_HOLD_CYCLES = 300;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [GSIZE_W-1:0]  cfg_wdata;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [DATA_W-1:0]   s_axis_tdata;
    logic                s_axis_tlast;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [DATA_W-1:0]   m_axis_tdata;
    logic                m_axis_tlast;

    reorder_scoreboard   sb;
    int                  cycle_count;
    int                  tx_gap_max;
    int                  rx_count;
    bit                  rx_hold_req;

    group_reverse_stream_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("group_reverse_stream_top test failed");
            $finish;
        end
    end

    task automatic send_item(input logic [DATA_W-1:0] value, input logic last);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        sb.note_input(value, last);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_group_size(input logic [GSIZE_W-1:0] size_code);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= size_code;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.write_group_size(size_code);
    endtask

    task automatic run_phase(input logic [GSIZE_W-1:0] size_code, input int items,
                             input bit no_gaps, input bit hold_rx);
        int          sent;
        int          seq_len;
        logic [DATA_W-1:0] value;
        logic        last;
        set_group_size(size_code);
        tx_gap_max = no_gaps ? 0 : 12;
        if (hold_rx)
        begin
            rx_hold_req = 1'b1;
        end
        sent = 0;
        while (sent < items)
        begin
            seq_len = $urandom_range(1, 20);
            for (int pos = 0; pos < seq_len && sent < items; pos++)
            begin
                case ($urandom_range(0, 7))
                    0: value = 32'h8000_0000;
                    1: value = 32'h7fff_ffff;
                    2: value = 32'h0000_0000;
                    3: value = 32'hffff_ffff;
                    default: value = $urandom;
                endcase
                last = (pos == seq_len - 1);
                if ($urandom_range(0, 9) == 0)
                begin
                    last = ~last;
                end
                send_item(value, last);
                sent++;
            end
        end
    endtask

    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                stall = RX_HOLD_CYCLES;
            end
            else if ((rx_count / 25) % 3 == 2)
            begin
                stall = 0;
            end
            else
            begin
                stall = $urandom_range(0, 12);
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
            begin
                @(posedge clk);
            end
            sb.check_result(m_axis_tdata, m_axis_tlast);
            rx_count++;
        end
    end

    initial
    begin
        sb            = new();
        cycle_count   = 0;
        rx_count      = 0;
        rx_hold_req   = 1'b0;
        tx_gap_max    = 12;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset group size: one reversed pair, then a one-value short tail.
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h7fff_ffff, 1'b0);
        send_item(32'hffff_ffff, 1'b1);

        // A size of zero behaves as pass-through.
        set_group_size(5'd0);
        send_item(32'h0000_0000, 1'b0);
        send_item(32'h1234_5678, 1'b1);

        // The group fills exactly on the final element.
        set_group_size(5'd3);
        send_item(32'h0000_0001, 1'b0);
        send_item(32'h0000_0002, 1'b0);
        send_item(32'h0000_0003, 1'b1);

        // An oversized setting saturates; lowering it mid-group flushes the held values.
        set_group_size(5'd31);
        send_item(32'hdead_beef, 1'b0);
        send_item(32'h8000_0001, 1'b0);
        send_item(32'h7fff_fffe, 1'b0);
        send_item(32'h5555_5555, 1'b0);
        send_item(32'haaaa_aaaa, 1'b0);
        set_group_size(5'd4);
        send_item(32'h0f0f_0f0f, 1'b0);

        run_phase(5'd1, 11, 1'b0, 1'b0);
        run_phase(5'd16, 11, 1'b1, 1'b0);
        run_phase(5'd4, 40, 1'b1, 1'b1);
        run_phase(5'd5, 11, 1'b0, 1'b0);
        run_phase(5'd2, 11, 1'b1, 1'b0);
        run_phase(5'd31, 11, 1'b0, 1'b0);
        run_phase(5'd0, 11, 1'b0, 1'b0);
        run_phase(5'd7, 11, 1'b1, 1'b0);
        run_phase(5'd16, 11, 1'b0, 1'b0);

        wait_idle();
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("group_reverse_stream_top test passed");
        end
        else
        begin
            $display("group_reverse_stream_top test failed");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
src/grs_pkg.sv
src/grs_ram.sv
src/grs_front.sv
src/grs_desc_queue.sv
src/grs_back.sv
src/group_reverse_stream_top.sv
tb/sv/tb_group_reverse_stream_top.sv
